>>> rtl/core/sjf_pkg.sv
`default_nettype none

package sjf_pkg;

	localparam int MAX_JOBS  = 16;
	localparam int TIME_BITS = 16;
	localparam int ID_W      = 8;
	localparam int RES_W     = 20;

	localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W  = $clog2(MAX_JOBS + 1);
	// The clock can pass the latest arrival by at most MAX_JOBS full bursts.
	localparam int TNOW_W = TIME_BITS + CNT_W;
	localparam int SUM_W  = (TNOW_W + 1 > RES_W) ? TNOW_W + 1 : RES_W + 1;

	localparam logic [SUM_W-1:0] RES_MAX = SUM_W'((64'd1 << RES_W) - 64'd1);

	typedef enum logic {
		SCAN_PICK,
		SCAN_ORDER
	} scan_mode_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		scan_mode_t mode;
	} scan_ctl_t;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [TIME_BITS-1:0] arr;
		logic [TIME_BITS-1:0] burst;
		logic [RES_W-1:0]     wt;
		logic                 done;
	} entry_t;

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     idx;
		entry_t               job;
		logic                 pending;
		logic [TIME_BITS-1:0] next_arr;
	} scan_res_t;

	function automatic logic [RES_W-1:0] sat_res(input logic [SUM_W-1:0] v);
		logic [RES_W-1:0] r;
		if (v > RES_MAX) begin
			r = RES_MAX[RES_W-1:0];
		end else begin
			r = v[RES_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sjf_if.sv
`default_nettype none

interface sjf_job_if import sjf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ID_W-1:0]      process_id;
	logic [TIME_BITS-1:0] arrival_time;
	logic [TIME_BITS-1:0] burst_time;
	logic                 last_process;

	modport source (output valid, process_id, arrival_time, burst_time, last_process,
		input ready);
	modport sink (input valid, process_id, arrival_time, burst_time, last_process,
		output ready);
endinterface

interface sjf_res_if import sjf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [ID_W-1:0]      out_process_id;
	logic [TIME_BITS-1:0] out_arrival;
	logic [TIME_BITS-1:0] out_burst;
	logic [RES_W-1:0]     waiting_time;
	logic [RES_W-1:0]     turnaround_time;
	logic                 last_result;
	logic                 dropped_flag;

	modport source (output valid, out_process_id, out_arrival, out_burst, waiting_time,
		turnaround_time, last_result, dropped_flag, input ready);
	modport sink (input valid, out_process_id, out_arrival, out_burst, waiting_time,
		turnaround_time, last_result, dropped_flag, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sjf_scan.sv
`default_nettype none

module sjf_scan import sjf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scan_ctl_t         ctl,
	input  wire entry_t            ent,
	input  wire logic [IDX_W-1:0]  k,
	input  wire logic [TNOW_W-1:0] time_now,
	output scan_res_t              res
);

	logic                 found_q;
	logic                 pend_q;
	logic [IDX_W-1:0]     idx_q;
	entry_t               best_q;
	logic [TIME_BITS-1:0] next_q;

	logic eff_found;
	logic eff_pend;
	logic arrived;
	logic better;
	logic take;
	logic pend_upd;

	always_comb begin
		eff_found = found_q & ~ctl.first;
		eff_pend  = pend_q & ~ctl.first;
		arrived   = TNOW_W'(ent.arr) <= time_now;
		take      = 1'b0;
		pend_upd  = 1'b0;
		better    = 1'b0;
		case (ctl.mode)
			SCAN_PICK: begin
				// Shorter burst wins; equal bursts go to the earlier arrival, and
				// the index order of the scan settles the rest.
				better = (ent.burst < best_q.burst) ||
					((ent.burst == best_q.burst) && (ent.arr < best_q.arr));
				take     = ctl.valid && !ent.done && arrived && (!eff_found || better);
				pend_upd = ctl.valid && !ent.done && !arrived &&
					(!eff_pend || (ent.arr < next_q));
			end
			SCAN_ORDER: begin
				// Here the done flag marks jobs not yet reported.
				better = ent.arr < best_q.arr;
				take   = ctl.valid && ent.done && (!eff_found || better);
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (ctl.valid) begin
			found_q <= eff_found | take;
			pend_q  <= eff_pend | pend_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= ent;
			idx_q  <= k;
		end
		if (pend_upd) begin
			next_q <= ent.arr;
		end
	end

	assign res.found    = found_q;
	assign res.idx      = idx_q;
	assign res.job      = best_q;
	assign res.pending  = pend_q;
	assign res.next_arr = next_q;

endmodule

`default_nettype wire

>>> rtl/core/nonpreemptive_sjf_scheduler.sv
// Jobs load at one item per cycle; the item marked last starts scheduling.
// Each scheduling choice is one pass of the shared compare unit over the n stored
// jobs plus a commit step; idle gaps add one extra pass each.
// Each result then takes an ordering pass, a fill step and an output state, and waits for ready.
// Asynchronous active-low reset empties the table; no clearing pass is needed.
`default_nettype none

module nonpreemptive_sjf_scheduler import sjf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	sjf_job_if.sink  job,
	sjf_res_if.source res
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_PICK,
		S_COMMIT,
		S_OSCAN,
		S_OFILL,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     k_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     fin_q;
	logic [CNT_W-1:0]     emit_q;
	logic [TNOW_W-1:0]    time_q;
	logic                 ovf_q;
	logic [MAX_JOBS-1:0]  done_q;

	logic                 out_valid_q;
	logic [ID_W-1:0]      out_id_q;
	logic [TIME_BITS-1:0] out_arr_q;
	logic [TIME_BITS-1:0] out_burst_q;
	logic [RES_W-1:0]     out_wait_q;
	logic [RES_W-1:0]     out_turn_q;
	logic                 out_last_q;
	logic                 out_drop_q;

	logic [ID_W-1:0]      id_mem_q    [MAX_JOBS];
	logic [TIME_BITS-1:0] arr_mem_q   [MAX_JOBS];
	logic [TIME_BITS-1:0] burst_mem_q [MAX_JOBS];
	logic [RES_W-1:0]     wt_mem_q    [MAX_JOBS];

	logic             in_acc;
	logic             room;
	logic [CNT_W-1:0] cnt_m1;
	logic             k_last;
	scan_ctl_t        sctl;
	entry_t           ent;
	scan_res_t        sr;

	assign job.ready = (state_q == S_LOAD);
	assign in_acc    = job.valid && job.ready;
	assign room      = cnt_q < CNT_W'(MAX_JOBS);
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign k_last    = (CNT_W'(k_q) == cnt_m1);

	always_comb begin
		sctl.valid = (state_q == S_PICK) || (state_q == S_OSCAN);
		sctl.first = (k_q == '0);
		sctl.mode  = (state_q == S_OSCAN) ? SCAN_ORDER : SCAN_PICK;
		ent.id     = id_mem_q[k_q];
		ent.arr    = arr_mem_q[k_q];
		ent.burst  = burst_mem_q[k_q];
		ent.wt     = wt_mem_q[k_q];
		ent.done   = done_q[k_q];
	end

	sjf_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sctl),
		.ent      (ent),
		.k        (k_q),
		.time_now (time_q),
		.res      (sr)
	);

	always_ff @(posedge clk) begin
		if (in_acc && room) begin
			id_mem_q[cnt_q[IDX_W-1:0]]    <= job.process_id;
			arr_mem_q[cnt_q[IDX_W-1:0]]   <= job.arrival_time;
			burst_mem_q[cnt_q[IDX_W-1:0]] <= job.burst_time;
		end
		if ((state_q == S_COMMIT) && sr.found) begin
			wt_mem_q[sr.idx] <= sat_res(SUM_W'(time_q) - SUM_W'(sr.job.arr));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			k_q         <= '0;
			cnt_q       <= '0;
			fin_q       <= '0;
			emit_q      <= '0;
			time_q      <= '0;
			ovf_q       <= 1'b0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_arr_q   <= '0;
			out_burst_q <= '0;
			out_wait_q  <= '0;
			out_turn_q  <= '0;
			out_last_q  <= 1'b0;
			out_drop_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (job.last_process) begin
							time_q  <= '0;
							fin_q   <= '0;
							emit_q  <= '0;
							k_q     <= '0;
							state_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					if (k_last) begin
						state_q <= S_COMMIT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_COMMIT: begin
					k_q <= '0;
					if (sr.found) begin
						time_q         <= time_q + TNOW_W'(sr.job.burst);
						done_q[sr.idx] <= 1'b1;
						fin_q          <= fin_q + CNT_W'(1);
						state_q        <= (fin_q == cnt_m1) ? S_OSCAN : S_PICK;
					end else begin
						// Nothing has arrived yet: jump to the next arrival.
						time_q  <= TNOW_W'(sr.next_arr);
						state_q <= S_PICK;
					end
				end
				S_OSCAN: begin
					if (k_last) begin
						state_q <= S_OFILL;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_OFILL: begin
					out_valid_q    <= 1'b1;
					out_id_q       <= sr.job.id;
					out_arr_q      <= sr.job.arr;
					out_burst_q    <= sr.job.burst;
					out_wait_q     <= sr.job.wt;
					out_turn_q     <= sat_res(SUM_W'(sr.job.wt) + SUM_W'(sr.job.burst));
					out_last_q     <= (emit_q == cnt_m1);
					out_drop_q     <= ovf_q;
					done_q[sr.idx] <= 1'b0;
					emit_q         <= emit_q + CNT_W'(1);
					k_q            <= '0;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_OSCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign res.valid           = out_valid_q;
	assign res.out_process_id  = out_id_q;
	assign res.out_arrival     = out_arr_q;
	assign res.out_burst       = out_burst_q;
	assign res.waiting_time    = out_wait_q;
	assign res.turnaround_time = out_turn_q;
	assign res.last_result     = out_last_q;
	assign res.dropped_flag    = out_drop_q;

`ifndef SYNTHESIS
	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		job.ready |-> !res.valid)
		else $error("input ready while a result is pending");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_JOBS))
		else $error("job count beyond table size");

	a_commit_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && sr.found) |=> done_q[$past(sr.idx)])
		else $error("scheduled job not marked done");

	a_commit_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |-> (sr.found || sr.pending))
		else $error("scheduling pass found neither a job nor a pending arrival");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last_result) |-> (done_q == '0))
		else $error("final result with jobs still unreported");
`endif

endmodule

`default_nettype wire
